>>> rtl/core/dtv_pkg.sv
`default_nettype none
package dtv_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int VALUE_WIDTH = 12;
   localparam logic [VALUE_WIDTH-1:0] SAT_MAX = 12'd4095;
   localparam logic [VALUE_WIDTH-1:0] YEAR_MIN = 12'd1901;
   localparam logic [VALUE_WIDTH-1:0] YEAR_LIMIT = 12'd2100;
   localparam logic [VALUE_WIDTH-1:0] MONTH_MAX = 12'd12;
   localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
   localparam logic [3:0] MONTH_FEB = 4'd2;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_PLUS = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_SLASH = 8'd47;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   localparam logic [2:0] CLS_SPACE = 3'd0;
   localparam logic [2:0] CLS_PLUS = 3'd1;
   localparam logic [2:0] CLS_MINUS = 3'd2;
   localparam logic [2:0] CLS_DIGIT = 3'd3;
   localparam logic [2:0] CLS_SLASH = 3'd4;
   localparam logic [2:0] CLS_OTHER = 3'd5;
   localparam logic [2:0] CLS_END = 3'd6;

   localparam logic [1:0] FMT_DMY = 2'd0;
   localparam logic [1:0] FMT_MDY = 2'd1;
   localparam logic [1:0] FMT_YMD = 2'd2;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_data_type;

   typedef struct packed {
      logic                   date_valid;
      logic [VALUE_WIDTH-1:0] year_value;
      logic [VALUE_WIDTH-1:0] month_value;
      logic [VALUE_WIDTH-1:0] day_value;
   } rsp_data_type;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] digit;
   } token_type;

   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] days;
      case (month)
         4'd2: days = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/date_text_validator_top.sv
// Date text validator.
// The request channel (req_valid, req_stall, req_data) carries one character
// of date text per transaction, or an end marker that closes the string.
// Each end marker produces exactly one transaction on the response channel
// (rsp_valid, rsp_stall, rsp_data): a valid flag plus year, month and day,
// all zero when the date is rejected. Other characters produce no response.
// The csr channel (csr_valid, csr_ready, csr_data) writes the field order;
// csr_ready is always high. Write it only while no string is in progress.
// Throughput: one character per cycle while req_stall is low, set by the
// parse step in the back end. An accepted end marker is written into the
// character queue and loads the response register as it leaves the queue,
// so each response comes from a register.
// When the receiver stalls, the response holds; the back end keeps parsing
// characters until the next end marker, the queue fills and req_stall rises
// once the queue is full.
// Reset clears the queue, the parse state and the response valid flag and
// sets the field order to day/month/year.
`default_nettype none
module date_text_validator_top #(
   parameter int QueueDepth = dtv_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  dtv_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output dtv_pkg::rsp_data_type rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [1:0]            csr_data
);

   dtv_pkg::token_type in_token;
   dtv_pkg::token_type q_token;
   logic               q_full;
   logic               q_present;
   logic               q_pop;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;

   dtv_classify u_classify (
      .req_data (req_data),
      .token    (in_token)
   );

   dtv_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (in_token),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_present),
      .pop_data  (q_token)
   );

   dtv_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .tok_present (q_present),
      .tok         (q_token),
      .tok_pop     (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/core/dtv_classify.sv
`default_nettype none
module dtv_classify (
   input  dtv_pkg::req_data_type req_data,
   output dtv_pkg::token_type    token
);

   logic is_space;
   logic is_digit;

   assign is_space = (req_data.text_char == dtv_pkg::CHAR_SPACE) ||
                     ((req_data.text_char >= dtv_pkg::CHAR_TAB) &&
                      (req_data.text_char <= dtv_pkg::CHAR_CR));
   assign is_digit = (req_data.text_char >= dtv_pkg::CHAR_ZERO) &&
                     (req_data.text_char <= dtv_pkg::CHAR_NINE);

   always_comb begin
      token.digit = req_data.text_char[3:0];
      if (req_data.end_of_text) begin
         token.cls = dtv_pkg::CLS_END;
      end else if (is_space) begin
         token.cls = dtv_pkg::CLS_SPACE;
      end else if (is_digit) begin
         token.cls = dtv_pkg::CLS_DIGIT;
      end else if (req_data.text_char == dtv_pkg::CHAR_PLUS) begin
         token.cls = dtv_pkg::CLS_PLUS;
      end else if (req_data.text_char == dtv_pkg::CHAR_MINUS) begin
         token.cls = dtv_pkg::CLS_MINUS;
      end else if (req_data.text_char == dtv_pkg::CHAR_SLASH) begin
         token.cls = dtv_pkg::CLS_SLASH;
      end else begin
         token.cls = dtv_pkg::CLS_OTHER;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dtv_queue.sv
`default_nettype none
module dtv_queue #(
   parameter int Depth = dtv_pkg::QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  dtv_pkg::token_type  push_data,
   output logic                full,
   input  wire                 pop,
   output logic                not_empty,
   output dtv_pkg::token_type  pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(Depth);

   dtv_pkg::token_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full = (count_ff == DepthCount);
   assign not_empty = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dtv_parse.sv
`default_nettype none
module dtv_parse (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_write,
   input  wire  [1:0]            csr_data,
   input  wire                   tok_present,
   input  dtv_pkg::token_type    tok,
   output logic                  tok_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output dtv_pkg::rsp_data_type rsp_data
);

   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_SIGN = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_SEP = 2'd3;

   localparam int VW = dtv_pkg::VALUE_WIDTH;

   logic [1:0]    format_ff;
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    field_ff, field_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic [VW-1:0] first_ff, first_in;
   logic [VW-1:0] second_ff, second_in;
   logic          failed_ff, failed_in;
   logic          next_field;

   logic          rsp_valid_ff;
   dtv_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic          is_end;
   logic [VW+3:0] acc_wide;
   logic [VW-1:0] acc_sat;

   logic          fmt_ok;
   logic          ok;
   logic [VW-1:0] year;
   logic [VW-1:0] month;
   logic [VW-1:0] day;
   logic [4:0]    lim;

   assign is_end = (tok.cls == dtv_pkg::CLS_END);
   assign tok_pop = tok_present && (!is_end || !rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign acc_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                     {{VW{1'b0}}, tok.digit};
   assign acc_sat = (acc_wide > {4'b0000, dtv_pkg::SAT_MAX}) ? dtv_pkg::SAT_MAX
                                                             : acc_wide[VW-1:0];

   always_comb begin
      phase_in = phase_ff;
      field_in = field_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      first_in = first_ff;
      second_in = second_ff;
      failed_in = failed_ff;
      next_field = 1'b0;
      if (tok_pop) begin
         if (is_end) begin
            phase_in = PH_LEAD;
            field_in = '0;
            acc_in = '0;
            neg_in = 1'b0;
            first_in = '0;
            second_in = '0;
            failed_in = 1'b0;
         end else if (!failed_ff) begin
            unique case (phase_ff)
               PH_LEAD: begin
                  case (tok.cls)
                     dtv_pkg::CLS_SPACE: ;
                     dtv_pkg::CLS_PLUS: phase_in = PH_SIGN;
                     dtv_pkg::CLS_MINUS: begin
                        neg_in = 1'b1;
                        phase_in = PH_SIGN;
                     end
                     dtv_pkg::CLS_DIGIT: begin
                        acc_in = {{(VW-4){1'b0}}, tok.digit};
                        phase_in = PH_DIGIT;
                     end
                     default: failed_in = 1'b1;
                  endcase
               end
               PH_SIGN: begin
                  if (tok.cls == dtv_pkg::CLS_DIGIT) begin
                     acc_in = {{(VW-4){1'b0}}, tok.digit};
                     phase_in = PH_DIGIT;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_DIGIT: begin
                  if (tok.cls == dtv_pkg::CLS_DIGIT) begin
                     acc_in = acc_sat;
                  end else if (field_ff >= 2'd2) begin
                     failed_in = 1'b1;
                  end else if (tok.cls == dtv_pkg::CLS_SPACE) begin
                     phase_in = PH_SEP;
                  end else if (tok.cls == dtv_pkg::CLS_SLASH) begin
                     next_field = 1'b1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_SEP: begin
                  if (tok.cls == dtv_pkg::CLS_SPACE) begin
                     phase_in = PH_SEP;
                  end else if (tok.cls == dtv_pkg::CLS_SLASH) begin
                     next_field = 1'b1;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: failed_in = 1'b1;
            endcase
            if (next_field) begin
               if (field_ff == 2'd0) begin
                  first_in = acc_ff;
               end else begin
                  second_in = acc_ff;
               end
               field_in = field_ff + 2'd1;
               acc_in = '0;
               phase_in = PH_LEAD;
            end
         end
      end
   end

   always_comb begin
      fmt_ok = 1'b1;
      year = acc_ff;
      month = second_ff;
      day = first_ff;
      unique case (format_ff)
         dtv_pkg::FMT_DMY: begin
            day = first_ff;
            month = second_ff;
            year = acc_ff;
         end
         dtv_pkg::FMT_MDY: begin
            month = first_ff;
            day = second_ff;
            year = acc_ff;
         end
         dtv_pkg::FMT_YMD: begin
            year = first_ff;
            month = second_ff;
            day = acc_ff;
         end
         default: fmt_ok = 1'b0;
      endcase
   end

   always_comb begin
      lim = dtv_pkg::month_days(month[3:0]);
      if ((month[3:0] == dtv_pkg::MONTH_FEB) && (year[1:0] == 2'b00)) begin
         lim = dtv_pkg::FEB_LEAP_DAYS;
      end
      ok = !failed_ff && !neg_ff && (field_ff == 2'd2) && (phase_ff == PH_DIGIT) &&
           fmt_ok && (year >= dtv_pkg::YEAR_MIN) && (year < dtv_pkg::YEAR_LIMIT) &&
           (month != '0) && (month <= dtv_pkg::MONTH_MAX) && (day != '0) &&
           (day <= {{(VW-5){1'b0}}, lim});
      rsp_data_in.date_valid = ok;
      rsp_data_in.year_value = ok ? year : '0;
      rsp_data_in.month_value = ok ? month : '0;
      rsp_data_in.day_value = ok ? day : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= dtv_pkg::FMT_DMY;
         phase_ff <= PH_LEAD;
         field_ff <= '0;
         acc_ff <= '0;
         neg_ff <= 1'b0;
         first_ff <= '0;
         second_ff <= '0;
         failed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            format_ff <= csr_data;
         end
         phase_ff <= phase_in;
         field_ff <= field_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         first_ff <= first_in;
         second_ff <= second_in;
         failed_ff <= failed_in;
         if (tok_pop && is_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && is_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   localparam logic [1:0] FMT_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 310;

   typedef enum logic [1:0] {AT_LEAD, AT_SIGN, AT_DIGITS, AT_GAP} scan_state_type;

   typedef struct {
      dtv_pkg::req_data_type data;
      bit                    hold;
   } pending_char_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   dtv_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   dtv_pkg::rsp_data_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_data = dtv_pkg::FMT_DMY;

   pending_char_type      pending_chars[$];
   dtv_pkg::rsp_data_type expected_dates[$];
   logic [7:0]            text_buf[$];

   logic [1:0]     fmt_q;
   logic [1:0]     field_num;
   scan_state_type scan;
   logic [11:0]    acc;
   logic           neg_seen;
   logic [11:0]    first_val;
   logic [11:0]    second_val;
   logic           failed;

   logic req_taken = 1'b0;
   int   csr_writes = 0;
   int   mismatches = 0;
   int   dates_checked = 0;
   int   dates_valid = 0;
   int   items_queued = 0;
   int   cycle_count = 0;
   int   send_gap = 0;
   int   send_calm = 0;
   int   stall_left = 0;
   int   stall_calm = 0;
   bit   hold_next = 1'b0;

   date_text_validator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int days_in(input int unsigned month, input int unsigned year);
      case (month)
         2: return (year % 4 == 0) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == dtv_pkg::CHAR_SPACE ||
             (c >= dtv_pkg::CHAR_TAB && c <= dtv_pkg::CHAR_CR);
   endfunction

   task automatic clear_scan();
      field_num = 2'd0;
      scan = AT_LEAD;
      acc = '0;
      neg_seen = 1'b0;
      first_val = '0;
      second_val = '0;
      failed = 1'b0;
   endtask

   task automatic close_field();
      if (field_num == 2'd0) begin
         first_val = acc;
      end else begin
         second_val = acc;
      end
      field_num = field_num + 2'd1;
      acc = '0;
      scan = AT_LEAD;
   endtask

   task automatic parse_char(input logic [7:0] c);
      int unsigned grown;
      bit digit;
      digit = c >= dtv_pkg::CHAR_ZERO && c <= dtv_pkg::CHAR_NINE;
      if (failed) return;
      case (scan)
         AT_LEAD: begin
            if (is_blank(c)) begin
            end else if (c == dtv_pkg::CHAR_PLUS || c == dtv_pkg::CHAR_MINUS) begin
               if (c == dtv_pkg::CHAR_MINUS) neg_seen = 1'b1;
               scan = AT_SIGN;
            end else if (digit) begin
               acc = 12'(c - dtv_pkg::CHAR_ZERO);
               scan = AT_DIGITS;
            end else begin
               failed = 1'b1;
            end
         end
         AT_SIGN: begin
            if (digit) begin
               acc = 12'(c - dtv_pkg::CHAR_ZERO);
               scan = AT_DIGITS;
            end else begin
               failed = 1'b1;
            end
         end
         AT_DIGITS: begin
            if (digit) begin
               grown = 32'(acc) * 10 + 32'(c - dtv_pkg::CHAR_ZERO);
               acc = (grown > 32'(dtv_pkg::SAT_MAX)) ? dtv_pkg::SAT_MAX : grown[11:0];
            end else if (field_num >= 2'd2) begin
               failed = 1'b1;
            end else if (is_blank(c)) begin
               scan = AT_GAP;
            end else if (c == dtv_pkg::CHAR_SLASH) begin
               close_field();
            end else begin
               failed = 1'b1;
            end
         end
         default: begin
            if (is_blank(c)) begin
            end else if (c == dtv_pkg::CHAR_SLASH) begin
               close_field();
            end else begin
               failed = 1'b1;
            end
         end
      endcase
   endtask

   function automatic dtv_pkg::rsp_data_type judge_date();
      dtv_pkg::rsp_data_type r;
      bit ok;
      logic [11:0] y, m, d;
      ok = !failed && !neg_seen && field_num == 2'd2 && scan == AT_DIGITS;
      case (fmt_q)
         dtv_pkg::FMT_DMY: begin
            d = first_val; m = second_val; y = acc;
         end
         dtv_pkg::FMT_MDY: begin
            m = first_val; d = second_val; y = acc;
         end
         dtv_pkg::FMT_YMD: begin
            y = first_val; m = second_val; d = acc;
         end
         default: begin
            ok = 1'b0; y = '0; m = '0; d = '0;
         end
      endcase
      if (ok) ok = y >= dtv_pkg::YEAR_MIN && y < dtv_pkg::YEAR_LIMIT &&
                   m >= 1 && m <= dtv_pkg::MONTH_MAX && d >= 1;
      if (ok) ok = d <= days_in(m, y);
      r.date_valid = ok;
      r.year_value = ok ? y : '0;
      r.month_value = ok ? m : '0;
      r.day_value = ok ? d : '0;
      return r;
   endfunction

   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // request driver
   always @(negedge clock) begin
      pending_char_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_chars.size() > 0 &&
                      !(pending_chars[0].hold && expected_dates.size() > 0)) begin
            nxt = pending_chars.pop_front();
            req_data <= nxt.data;
            req_valid <= 1'b1;
            send_gap = idle_len(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = idle_len(stall_calm);
         rsp_stall <= stall_left > 0;
         if (stall_left > 0) stall_left--;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      dtv_pkg::rsp_data_type want;
      if (reset) begin
         clear_scan();
         fmt_q = dtv_pkg::FMT_DMY;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            fmt_q = csr_data;
            csr_writes <= csr_writes + 1;
         end
         if (req_valid && !req_stall) begin
            if (req_data.end_of_text) begin
               expected_dates.push_back(judge_date());
               clear_scan();
            end else begin
               parse_char(req_data.text_char);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transaction: valid=%0d y=%0d m=%0d d=%0d",
                           rsp_data.date_valid, rsp_data.year_value,
                           rsp_data.month_value, rsp_data.day_value);
            end else begin
               want = expected_dates.pop_front();
               dates_checked++;
               if (rsp_data.date_valid) dates_valid++;
               if (rsp_data.date_valid !== want.date_valid ||
                   rsp_data.year_value !== want.year_value ||
                   rsp_data.month_value !== want.month_value ||
                   rsp_data.day_value !== want.day_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"date mismatch: expected valid=%0d y=%0d m=%0d d=%0d, ",
                               "got valid=%0d y=%0d m=%0d d=%0d"},
                              want.date_valid, want.year_value, want.month_value,
                              want.day_value, rsp_data.date_valid, rsp_data.year_value,
                              rsp_data.month_value, rsp_data.day_value);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic put_item(input logic [7:0] c, input bit eot);
      pending_char_type it;
      it.data.text_char = c;
      it.data.end_of_text = eot;
      it.hold = hold_next;
      hold_next = 1'b0;
      pending_chars.push_back(it);
      items_queued++;
   endtask

   task automatic flush_text();
      foreach (text_buf[i]) put_item(text_buf[i], 1'b0);
      text_buf.delete();
      put_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic put_string(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      flush_text();
   endtask

   function automatic logic [7:0] blank_char();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? dtv_pkg::CHAR_SPACE : dtv_pkg::CHAR_TAB + 8'(r);
   endfunction

   task automatic add_number(input int unsigned v);
      logic [7:0] dg[$];
      int r;
      do begin
         dg.push_front(dtv_pkg::CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      r = $urandom_range(0, 99);
      if (r < 6) text_buf.push_back(dtv_pkg::CHAR_MINUS);
      else if (r < 14) text_buf.push_back(dtv_pkg::CHAR_PLUS);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) text_buf.push_back(dtv_pkg::CHAR_ZERO);
      foreach (dg[i]) text_buf.push_back(dg[i]);
   endtask

   task automatic put_date(input logic [1:0] order);
      int unsigned y, m, d;
      int unsigned f[3];
      int pos;
      y = $urandom_range(1901, 2099);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, days_in(m, y));
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: y = 1900;
               1: y = 1901;
               2: y = 2099;
               3: y = 2100;
               4: y = $urandom_range(0, 9999);
               default: y = $urandom_range(4095, 99999);
            endcase
         end
         1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 20);
         2: begin
            case ($urandom_range(0, 3))
               0: d = 0;
               1: d = days_in(m, y) + 1;
               2: d = days_in(m, y);
               default: d = $urandom_range(29, 40);
            endcase
         end
         3: begin
            m = 2;
            d = $urandom_range(28, 30);
         end
         default: ;
      endcase
      if (order == FMT_NONE || $urandom_range(0, 4) == 0) order = 2'($urandom_range(0, 2));
      case (order)
         dtv_pkg::FMT_DMY: f = '{d, m, y};
         dtv_pkg::FMT_MDY: f = '{m, d, y};
         default: f = '{y, m, d};
      endcase
      for (int i = 0; i < 3; i++) begin
         if (i > 0) begin
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 2)) text_buf.push_back(blank_char());
            text_buf.push_back(dtv_pkg::CHAR_SLASH);
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text_buf.push_back(blank_char());
         add_number(f[i]);
      end
      if ($urandom_range(0, 4) == 0) begin
         pos = $urandom_range(0, text_buf.size() - 1);
         case ($urandom_range(0, 4))
            0: text_buf.push_back(blank_char());
            1: text_buf.push_back(8'($urandom_range(0, 255)));
            2: text_buf[pos] = 8'($urandom_range(0, 255));
            3: text_buf.delete(pos);
            default: while (text_buf.size() > pos) void'(text_buf.pop_back());
         endcase
      end
      flush_text();
   endtask

   task automatic put_noise();
      int r;
      repeat ($urandom_range(0, 12)) begin
         r = $urandom_range(0, 99);
         if (r < 40) text_buf.push_back(8'($urandom_range(0, 255)));
         else if (r < 60) text_buf.push_back(dtv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         else if (r < 75) text_buf.push_back(dtv_pkg::CHAR_SLASH);
         else if (r < 90) text_buf.push_back(blank_char());
         else text_buf.push_back(r < 95 ? dtv_pkg::CHAR_PLUS : dtv_pkg::CHAR_MINUS);
      end
      flush_text();
   endtask

   task automatic wait_idle();
      while (pending_chars.size() > 0 || req_valid || expected_dates.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_format(input logic [1:0] v);
      int seen;
      seen = csr_writes;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [1:0] fmt_plan[6];
      int start;
      fmt_plan = '{dtv_pkg::FMT_MDY, dtv_pkg::FMT_YMD, FMT_NONE,
                   dtv_pkg::FMT_DMY, dtv_pkg::FMT_YMD, dtv_pkg::FMT_MDY};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      put_string("");
      put_string("\t+29/02/2096");
      put_string("1/1/99999");
      wait_idle();
      foreach (fmt_plan[p]) begin
         @(negedge clock);
         write_format(fmt_plan[p]);
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) begin
            if (items_queued - start > PHASE_ITEMS / 2 && p % 2 == 0) hold_next = 1'b1;
            if ($urandom_range(0, 99) < 80) put_date(fmt_plan[p]);
            else put_noise();
         end
         wait_idle();
      end
      if (expected_dates.size() != 0) mismatches++;
      $display("Sent %0d characters and end markers, checked %0d dates (%0d valid)",
               items_queued, dates_checked, dates_valid);
      $display("Covered %0d field order writes including the always-reject setting",
               csr_writes);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
